// ===== hw/rtl/tpt_pkg.sv =====
`default_nettype none

package tpt_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam int FULL_LEVEL = 25600;
    localparam int MIN_LEVEL  = 5120;
    localparam int PRED_TOP   = 23040;
    localparam int CUTOFF_Q   = 10240;
    localparam int HOT_Q      = 9728;
    localparam int ONE_DEG_Q  = 256;
    localparam int ILIM       = 25600;
    localparam int MS_DEFAULT = 1000;

    localparam int DIV_NW = 32;
    localparam int DIV_DW = 16;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_THR   = 3'd1;
    localparam logic [2:0] REG_CEIL  = 3'd2;
    localparam logic [2:0] REG_GP    = 3'd3;
    localparam logic [2:0] REG_GI    = 3'd4;
    localparam logic [2:0] REG_GD    = 3'd5;
    localparam logic [2:0] REG_LOOK  = 3'd6;
    localparam logic [2:0] REG_WLEN  = 3'd7;

    // strategy codes
    localparam logic [1:0] MODE_CEIL = 2'd0;
    localparam logic [1:0] MODE_PID  = 2'd1;
    localparam logic [1:0] MODE_PRED = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] thr;
        logic [14:0]        ceil;
        logic [15:0]        gp;
        logic [15:0]        gi;
        logic [15:0]        gd;
        logic [7:0]         look;
        logic [6:0]         wlen;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CUT,
        OP_CEIL,
        OP_P_ERR,
        OP_P_MUL1,
        OP_P_DIV1,
        OP_P_INTEG,
        OP_P_MUL2,
        OP_P_DIV2,
        OP_P_DER,
        OP_P_MUL3,
        OP_P_MUL4,
        OP_P_MUL5,
        OP_P_ACC,
        OP_P_SCL,
        OP_P_LVL,
        OP_R_WR,
        OP_R_MUL,
        OP_R_DIV,
        OP_R_CMP,
        OP_D_MUL,
        OP_D_DIV,
        OP_D_STAT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_in;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic       div_busy;
        logic [1:0] mode;
        logic       cut;
        logic       fill_ge2;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpt_ram.sv =====
`default_nettype none

module tpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tpt_div.sv =====
`default_nettype none

module tpt_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tpt_pkg::DIV_NW-1:0] dividend,
    input  wire logic [tpt_pkg::DIV_DW-1:0] divisor,
    output logic                            busy,
    output logic      [tpt_pkg::DIV_NW-1:0] quotient
);

    import tpt_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] div_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DIV_DW:0]   partial;
    logic              fits;

    // one quotient bit per cycle, restoring
    assign partial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits    = partial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(DIV_NW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? DIV_DW'(partial - {1'b0, div_reg}) : partial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tpt_datapath.sv =====
`default_nettype none

module tpt_datapath #(
    parameter int RING_DEPTH = tpt_pkg::RING_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tpt_pkg::cfg_t      cfg,
    input  wire logic               clear,
    input  wire tpt_pkg::cmd_t      cmd,
    output tpt_pkg::status_t        status,
    input  wire logic signed [15:0] temp_sample,
    input  wire logic [15:0]        max_power,
    input  wire logic [15:0]        elapsed_ms,
    output logic [15:0]             drive_power,
    output logic [14:0]             power_level,
    output logic                    emergency_cut,
    output logic [31:0]             hot_seconds,
    output logic [39:0]             energy_total
);

    import tpt_pkg::*;

    localparam int AW      = $clog2(RING_DEPTH);
    localparam int FW      = AW + 1;
    localparam int WIN_DEF = (30 <= RING_DEPTH) ? 30 : RING_DEPTH;
    // reciprocals for the constant divisors, ceil(2^36 / 125) and ceil(2^26 / 25)
    localparam int RCP_125 = 549755814;
    localparam int RCP_25  = 2684355;

    // kept state
    logic [14:0]        level_reg;
    logic signed [15:0] integ_reg;
    logic signed [16:0] last_err_reg;
    logic [AW-1:0]      head_reg;
    logic [FW-1:0]      fill_reg;
    logic [31:0]        hot_reg;
    logic [39:0]        energy_reg;

    // per-sample working registers
    logic signed [15:0] temp_reg;
    logic [15:0]        maxp_reg;
    logic [15:0]        ms_reg;
    logic signed [16:0] err_reg;
    logic signed [27:0] deriv_reg;
    logic signed [46:0] prod_reg;
    logic signed [51:0] sum_reg;
    logic               neg_reg;
    logic [15:0]        drive_reg;
    logic               cut_reg;
    logic [DIV_NW-1:0]  rcp_q_reg;
    logic               rcp_reg;

    logic [15:0] out_drive_reg;
    logic [14:0] out_level_reg;
    logic        out_cut_reg;
    logic [31:0] out_hot_reg;
    logic [39:0] out_energy_reg;

    logic signed [29:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [60:0] mul_p;
    logic               mul_en;
    logic               rcp_op;

    logic               div_start;
    logic [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]  div_den;
    logic               div_busy;
    logic [DIV_NW-1:0]  div_quo;
    logic [DIV_NW-1:0]  quo;
    logic signed [46:0] prod_mag;
    logic signed [32:0] q_s;

    logic [15:0]        ram_rdata;
    logic [AW-1:0]      rd_idx;
    logic [FW-1:0]      rd_diff;

    logic               win_ok;
    logic [FW-1:0]      win;
    logic [AW-1:0]      hu;
    logic [FW-1:0]      hu_inc;
    logic [AW-1:0]      head_next;
    logic [FW-1:0]      fill_next;

    logic [14:0]        ceil_lvl;
    logic signed [16:0] thr_lo;
    logic signed [16:0] err_c;
    logic signed [25:0] integ_sum;
    logic signed [51:0] lvl_t;
    logic [15:0]        lvl_sum;
    logic signed [26:0] qv;
    logic signed [26:0] pred;
    logic signed [27:0] over;
    logic [15:0]        over10;
    logic [40:0]        esum;

    // divider operands, sign handled around the unsigned core
    assign prod_mag = prod_reg[46] ? -prod_reg : prod_reg;

    // shared multiplier, one product a cycle
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_P_MUL1:
            begin
                mul_a = 30'(err_reg);
                mul_b = $signed({15'd0, ms_reg});
            end
            OP_P_DIV1:
            begin
                // divide by 1000 as shift by 3 then reciprocal of 125
                mul_a = $signed({1'b0, prod_mag[31:3]});
                mul_b = 31'(RCP_125);
            end
            OP_P_MUL2:
            begin
                mul_a = 30'(18'(err_reg) - 18'(last_err_reg));
                mul_b = 31'sd1000;
            end
            OP_P_MUL3:
            begin
                mul_a = 30'(err_reg);
                mul_b = $signed({15'd0, cfg.gp});
            end
            OP_P_MUL4:
            begin
                mul_a = 30'(integ_reg);
                mul_b = $signed({15'd0, cfg.gi});
            end
            OP_P_MUL5:
            begin
                mul_a = 30'(deriv_reg);
                mul_b = $signed({15'd0, cfg.gd});
            end
            OP_R_MUL:
            begin
                mul_a = 30'(17'(temp_reg) - 17'($signed(ram_rdata)));
                mul_b = $signed({23'd0, cfg.look});
            end
            OP_D_MUL:
            begin
                mul_a = $signed({15'd0, level_reg});
                mul_b = $signed({15'd0, maxp_reg});
            end
            OP_D_DIV:
            begin
                // divide by 25600 as shift by 10 then reciprocal of 25
                mul_a = $signed({9'd0, prod_mag[30:10]});
                mul_b = 31'(RCP_25);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign rcp_op = (cmd.op == OP_P_DIV1) || (cmd.op == OP_D_DIV);

    always_comb
    begin
        div_start = 1'b1;
        div_num   = prod_mag[DIV_NW-1:0];
        div_den   = 16'd1;
        case (cmd.op)
            OP_P_DIV2: div_den = ms_reg;
            OP_R_DIV:  div_den = 16'(fill_reg - FW'(1));
            default:   div_start = 1'b0;
        endcase
    end

    tpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign quo = rcp_reg ? rcp_q_reg : div_quo;
    assign q_s = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    // ring window bookkeeping
    assign win_ok    = (cfg.wlen != '0) && (int'(cfg.wlen) <= RING_DEPTH);
    assign win       = win_ok ? FW'(cfg.wlen) : FW'(WIN_DEF);
    assign hu        = ({1'b0, head_reg} >= win) ? '0 : head_reg;
    assign hu_inc    = {1'b0, hu} + FW'(1);
    assign head_next = (hu_inc == win) ? '0 : hu_inc[AW-1:0];
    assign fill_next = (fill_reg < win) ? fill_reg + FW'(1) : fill_reg;
    assign rd_diff   = {1'b0, head_reg} - fill_reg;
    assign rd_idx    = ({1'b0, head_reg} < fill_reg) ? head_reg : rd_diff[AW-1:0];

    tpt_ram #(
        .WIDTH (16),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.op == OP_R_WR),
        .waddr (hu),
        .wdata (temp_reg),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // level arithmetic
    assign ceil_lvl  = (cfg.ceil > 15'(FULL_LEVEL)) ? 15'(FULL_LEVEL) : cfg.ceil;
    assign thr_lo    = 17'(cfg.thr) - 17'(ONE_DEG_Q);
    assign err_c     = 17'(cfg.thr) - 17'(temp_reg);
    assign integ_sum = 26'(integ_reg) + 26'(q_s);
    assign lvl_t     = sum_reg >>> 8;
    assign lvl_sum   = 16'(FULL_LEVEL) + lvl_t[15:0];
    assign qv        = status.fill_ge2 ? 27'(q_s) : '0;
    assign pred      = 27'(temp_reg) + qv;
    assign over      = 28'(pred) - 28'(cfg.thr);
    assign over10    = ({4'd0, over[11:0]} << 3) + ({4'd0, over[11:0]} << 1);
    assign esum      = {1'b0, energy_reg} + {25'd0, quo[15:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= 15'(FULL_LEVEL);
            integ_reg    <= '0;
            last_err_reg <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
            hot_reg      <= '0;
            energy_reg   <= '0;
        end
        else if (clear)
        begin
            level_reg    <= 15'(FULL_LEVEL);
            integ_reg    <= '0;
            last_err_reg <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
            hot_reg      <= '0;
            energy_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_CUT:
                begin
                    level_reg <= '0;
                end
                OP_CEIL:
                begin
                    if (temp_reg > cfg.thr)
                    begin
                        level_reg <= ceil_lvl;
                    end
                    else if (17'(temp_reg) < thr_lo)
                    begin
                        level_reg <= 15'(FULL_LEVEL);
                    end
                end
                OP_P_INTEG:
                begin
                    if (integ_sum > 26'(ILIM))
                    begin
                        integ_reg <= 16'(ILIM);
                    end
                    else if (integ_sum < -26'(ILIM))
                    begin
                        integ_reg <= -16'(ILIM);
                    end
                    else
                    begin
                        integ_reg <= integ_sum[15:0];
                    end
                end
                OP_P_DER:
                begin
                    last_err_reg <= err_reg;
                end
                OP_P_LVL:
                begin
                    if (lvl_t > 52'sd0)
                    begin
                        level_reg <= 15'(FULL_LEVEL);
                    end
                    else if (lvl_t < 52'(MIN_LEVEL - FULL_LEVEL))
                    begin
                        level_reg <= 15'(MIN_LEVEL);
                    end
                    else
                    begin
                        level_reg <= lvl_sum[14:0];
                    end
                end
                OP_R_WR:
                begin
                    head_reg <= head_next;
                    fill_reg <= fill_next;
                end
                OP_R_CMP:
                begin
                    if (over <= 28'sd0)
                    begin
                        level_reg <= 15'(FULL_LEVEL);
                    end
                    else if (over >= 28'sd2048)
                    begin
                        level_reg <= 15'(MIN_LEVEL);
                    end
                    else if (over <= 28'sd256)
                    begin
                        level_reg <= 15'(PRED_TOP);
                    end
                    else
                    begin
                        level_reg <= 15'(16'(FULL_LEVEL) - over10);
                    end
                end
                OP_D_STAT:
                begin
                    if (temp_reg > 16'(HOT_Q) && hot_reg != '1)
                    begin
                        hot_reg <= hot_reg + 32'd1;
                    end
                    energy_reg <= esum[40] ? '1 : esum[39:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            temp_reg  <= temp_sample;
            maxp_reg  <= max_power;
            ms_reg    <= (elapsed_ms == '0) ? 16'(MS_DEFAULT) : elapsed_ms;
            drive_reg <= '0;
            cut_reg   <= 1'b0;
        end
        if (mul_en)
        begin
            prod_reg <= 47'(mul_p);
        end
        if (div_start || rcp_op)
        begin
            neg_reg <= prod_reg[46];
        end
        case (cmd.op)
            OP_CUT:    cut_reg   <= 1'b1;
            OP_P_ERR:  err_reg   <= err_c;
            OP_P_DIV1:
            begin
                rcp_q_reg <= DIV_NW'(mul_p[60:36]);
                rcp_reg   <= 1'b1;
            end
            OP_P_DIV2: rcp_reg   <= 1'b0;
            OP_P_DER:  deriv_reg <= 28'(q_s);
            OP_P_MUL4: sum_reg   <= 52'(prod_reg);
            OP_P_MUL5: sum_reg   <= sum_reg + 52'(prod_reg);
            OP_P_ACC:  sum_reg   <= sum_reg + 52'(prod_reg);
            OP_P_SCL:  sum_reg   <= (sum_reg <<< 2) + sum_reg
                                    + (sum_reg[51] ? 52'sd255 : 52'sd0);
            OP_R_DIV:  rcp_reg   <= 1'b0;
            OP_D_DIV:
            begin
                rcp_q_reg <= DIV_NW'(mul_p[47:26]);
                rcp_reg   <= 1'b1;
            end
            OP_D_STAT: drive_reg <= quo[15:0];
            default:
            begin
            end
        endcase
        if (cmd.load_out)
        begin
            out_drive_reg  <= drive_reg;
            out_level_reg  <= level_reg;
            out_cut_reg    <= cut_reg;
            out_hot_reg    <= hot_reg;
            out_energy_reg <= energy_reg;
        end
    end

    assign status.div_busy = div_busy;
    assign status.mode     = cfg.mode;
    assign status.cut      = temp_reg >= 16'(CUTOFF_Q);
    assign status.fill_ge2 = fill_reg >= FW'(2);

    assign drive_power   = out_drive_reg;
    assign power_level   = out_level_reg;
    assign emergency_cut = out_cut_reg;
    assign hot_seconds   = out_hot_reg;
    assign energy_total  = out_energy_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tpt_ctrl.sv =====
`default_nettype none

module tpt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire tpt_pkg::status_t status,
    output tpt_pkg::cmd_t         cmd
);

    import tpt_pkg::*;

    typedef enum logic [29:0] {
        S_IDLE   = 30'b1 << 0,
        S_DISP   = 30'b1 << 1,
        S_CUT    = 30'b1 << 2,
        S_CEIL   = 30'b1 << 3,
        S_PERR   = 30'b1 << 4,
        S_PMUL1  = 30'b1 << 5,
        S_PDIV1  = 30'b1 << 6,
        S_PWAIT1 = 30'b1 << 7,
        S_PINTEG = 30'b1 << 8,
        S_PMUL2  = 30'b1 << 9,
        S_PDIV2  = 30'b1 << 10,
        S_PWAIT2 = 30'b1 << 11,
        S_PDER   = 30'b1 << 12,
        S_PMUL3  = 30'b1 << 13,
        S_PMUL4  = 30'b1 << 14,
        S_PMUL5  = 30'b1 << 15,
        S_PACC   = 30'b1 << 16,
        S_PSCL   = 30'b1 << 17,
        S_PLVL   = 30'b1 << 18,
        S_RWR    = 30'b1 << 19,
        S_RRD    = 30'b1 << 20,
        S_RMUL   = 30'b1 << 21,
        S_RDIV   = 30'b1 << 22,
        S_RWAIT  = 30'b1 << 23,
        S_RCMP   = 30'b1 << 24,
        S_DMUL   = 30'b1 << 25,
        S_DDIV   = 30'b1 << 26,
        S_DWAIT  = 30'b1 << 27,
        S_DSTAT  = 30'b1 << 28,
        S_FIN    = 30'b1 << 29
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.load_in  = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (status.mode != MODE_CEIL && status.mode != MODE_PID
                    && status.mode != MODE_PRED)
                begin
                    state_next = S_FIN;
                end
                else if (status.cut)
                begin
                    state_next = S_CUT;
                end
                else if (status.mode == MODE_CEIL)
                begin
                    state_next = S_CEIL;
                end
                else if (status.mode == MODE_PID)
                begin
                    state_next = S_PERR;
                end
                else
                begin
                    state_next = S_RWR;
                end
            end
            S_CUT:
            begin
                cmd.op     = OP_CUT;
                state_next = S_FIN;
            end
            S_CEIL:
            begin
                cmd.op     = OP_CEIL;
                state_next = S_DMUL;
            end
            S_PERR:
            begin
                cmd.op     = OP_P_ERR;
                state_next = S_PMUL1;
            end
            S_PMUL1:
            begin
                cmd.op     = OP_P_MUL1;
                state_next = S_PDIV1;
            end
            S_PDIV1:
            begin
                cmd.op     = OP_P_DIV1;
                state_next = S_PWAIT1;
            end
            S_PWAIT1:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_PINTEG;
                end
            end
            S_PINTEG:
            begin
                cmd.op     = OP_P_INTEG;
                state_next = S_PMUL2;
            end
            S_PMUL2:
            begin
                cmd.op     = OP_P_MUL2;
                state_next = S_PDIV2;
            end
            S_PDIV2:
            begin
                cmd.op     = OP_P_DIV2;
                state_next = S_PWAIT2;
            end
            S_PWAIT2:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_PDER;
                end
            end
            S_PDER:
            begin
                cmd.op     = OP_P_DER;
                state_next = S_PMUL3;
            end
            S_PMUL3:
            begin
                cmd.op     = OP_P_MUL3;
                state_next = S_PMUL4;
            end
            S_PMUL4:
            begin
                cmd.op     = OP_P_MUL4;
                state_next = S_PMUL5;
            end
            S_PMUL5:
            begin
                cmd.op     = OP_P_MUL5;
                state_next = S_PACC;
            end
            S_PACC:
            begin
                cmd.op     = OP_P_ACC;
                state_next = S_PSCL;
            end
            S_PSCL:
            begin
                cmd.op     = OP_P_SCL;
                state_next = S_PLVL;
            end
            S_PLVL:
            begin
                cmd.op     = OP_P_LVL;
                state_next = S_DMUL;
            end
            S_RWR:
            begin
                cmd.op     = OP_R_WR;
                state_next = S_RRD;
            end
            S_RRD:
            begin
                state_next = status.fill_ge2 ? S_RMUL : S_RCMP;
            end
            S_RMUL:
            begin
                cmd.op     = OP_R_MUL;
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                cmd.op     = OP_R_DIV;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_RCMP;
                end
            end
            S_RCMP:
            begin
                cmd.op     = OP_R_CMP;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.op     = OP_D_MUL;
                state_next = S_DDIV;
            end
            S_DDIV:
            begin
                cmd.op     = OP_D_DIV;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_DSTAT;
                end
            end
            S_DSTAT:
            begin
                cmd.op     = OP_D_STAT;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/thermal_power_throttle_unit.sv =====
// thermal power throttle: one temperature sample in, one result out
// input channel: in_valid / in_stall with temp_sample (signed Q8.8 C),
//   max_power (mW) and elapsed_ms; a transfer happens when valid and not stall
// output channel: out_valid / out_stall with drive_power, power_level,
//   emergency_cut, hot_seconds and energy_total, held while stalled
// configuration: APB-style port, register i at byte address 4*i, pready
//   always high; any write clears the throttle state and statistics
// the time from input transfer to out_valid depends on the strategy;
//   the bit-serial divider is used once for the predictive ramp and once
//   for the PID derivative; the constant divisions are reciprocal
//   multiplications
// an emergency cut goes from dispatch through the cut step to the output; the unused strategy code goes straight there
// one sample is worked at a time; the next is taken once the result
//   sits in the output register, even if the receiver stalls it
// a stalled result blocks only the hand-over of the following result
// reset: full power level, statistics zero, output channel empty;
//   the history ring needs no clearing pass
`default_nettype none

module thermal_power_throttle_unit #(
    parameter int RING_DEPTH = tpt_pkg::RING_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tpt_pkg::APB_AW-1:0] paddr,
    input  wire logic [tpt_pkg::APB_DW-1:0] pwdata,
    output logic      [tpt_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    // sample channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [15:0]         temp_sample,
    input  wire logic [15:0]                max_power,
    input  wire logic [15:0]                elapsed_ms,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [15:0]                     drive_power,
    output logic [14:0]                     power_level,
    output logic                            emergency_cut,
    output logic [31:0]                     hot_seconds,
    output logic [39:0]                     energy_total
);

    import tpt_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    cmd_t       cmd;
    status_t    status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register file, reset values as the power-on defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= MODE_CEIL;
            cfg_reg.thr  <= 16'sd9216;
            cfg_reg.ceil <= 15'd15360;
            cfg_reg.gp   <= 16'd1280;
            cfg_reg.gi   <= 16'd26;
            cfg_reg.gd   <= 16'd512;
            cfg_reg.look <= 8'd20;
            cfg_reg.wlen <= 7'd30;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_MODE: cfg_reg.mode <= pwdata[1:0];
                REG_THR:  cfg_reg.thr  <= $signed(pwdata[15:0]);
                REG_CEIL: cfg_reg.ceil <= pwdata[14:0];
                REG_GP:   cfg_reg.gp   <= pwdata[15:0];
                REG_GI:   cfg_reg.gi   <= pwdata[15:0];
                REG_GD:   cfg_reg.gd   <= pwdata[15:0];
                REG_LOOK: cfg_reg.look <= pwdata[7:0];
                REG_WLEN: cfg_reg.wlen <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // read-back mux
    always_comb
    begin
        case (reg_idx)
            REG_MODE: prdata = {30'd0, cfg_reg.mode};
            REG_THR:  prdata = {16'd0, cfg_reg.thr};
            REG_CEIL: prdata = {17'd0, cfg_reg.ceil};
            REG_GP:   prdata = {16'd0, cfg_reg.gp};
            REG_GI:   prdata = {16'd0, cfg_reg.gi};
            REG_GD:   prdata = {16'd0, cfg_reg.gd};
            REG_LOOK: prdata = {24'd0, cfg_reg.look};
            REG_WLEN: prdata = {25'd0, cfg_reg.wlen};
            default:  prdata = '0;
        endcase
    end

    // sequencer: walks each strategy step by step
    tpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic, kept state, history ring and output register
    tpt_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .clear         (cfg_wr),
        .cmd           (cmd),
        .status        (status),
        .temp_sample   (temp_sample),
        .max_power     (max_power),
        .elapsed_ms    (elapsed_ms),
        .drive_power   (drive_power),
        .power_level   (power_level),
        .emergency_cut (emergency_cut),
        .hot_seconds   (hot_seconds),
        .energy_total  (energy_total)
    );

    // a cut result never carries power
    a_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && emergency_cut |-> drive_power == 16'd0 && power_level == 15'd0)
        else $error("emergency result carries power");

    // level never above full scale
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> power_level <= 15'(FULL_LEVEL))
        else $error("power level above full scale");

    // a sample transfer always makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second sample taken while one is in work");

endmodule

`default_nettype wire
